[rtl/msd_pkg.sv]
// ----------------------------------------------------------------------------
// msd_pkg
// Shared codes and types of the multi-input shift debouncer.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int unsigned OpW = 3;

  localparam logic [OpW-1:0] OP_TICK  = 3'd0;
  localparam logic [OpW-1:0] OP_LEVEL = 3'd1;
  localparam logic [OpW-1:0] OP_RISE  = 3'd2;
  localparam logic [OpW-1:0] OP_FALL  = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR = 3'd4;

  localparam int unsigned PinW  = 32;
  localparam int unsigned ChanW = 8;

  typedef struct packed {
    logic tick;
    logic pin;
    logic clr_rise;
    logic clr_fall;
  } lane_ctrl_t;

  typedef struct packed {
    logic level;
    logic rise;
    logic fall;
  } lane_stat_t;

endpackage

[rtl/multi_input_shift_debouncer.sv]
// ----------------------------------------------------------------------------
// multi_input_shift_debouncer
// Shift-register debouncer over a bank of pins with sticky edge flags.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while s_axis_tready_o is high; each result is registered.
// Every channel is its own lane, so a tick updates all histories in the cycle
// it is accepted and a query reads (and clears) one lane in that same cycle.
// A two-entry output buffer parts the two sides: s_axis_tready_o drops only
// while two results wait to be taken. Operation travels in tuser.
// ----------------------------------------------------------------------------
module multi_input_shift_debouncer #(
  parameter int unsigned CHANNELS     = 32,
  parameter int unsigned HISTORY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] pin_levels, [39:32] channel
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // [0] value, [7:1] zero
);

  logic [msd_pkg::OpW-1:0]   op;
  logic [msd_pkg::PinW-1:0]  pins;
  logic [msd_pkg::ChanW-1:0] channel;
  logic                      acc, take, value;

  msd_pkg::lane_ctrl_t ctrl [CHANNELS];
  msd_pkg::lane_stat_t stat [CHANNELS];

  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic out_q, out_d, skid_q, skid_d;

  assign op      = s_axis_tuser_i;
  assign pins    = s_axis_tdata_i[31:0];
  assign channel = s_axis_tdata_i[39:32];
  assign acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign take    = out_vld_q && m_axis_tready_i;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic hit;
    assign hit = acc && (channel == msd_pkg::ChanW'(i));
    assign ctrl[i] = '{
      tick:     acc && (op == msd_pkg::OP_TICK),
      pin:      pins[i],
      clr_rise: hit && (op == msd_pkg::OP_RISE || op == msd_pkg::OP_CLEAR),
      clr_fall: hit && (op == msd_pkg::OP_FALL || op == msd_pkg::OP_CLEAR)
    };
    msd_lane #(.HISTORY_BITS(HISTORY_BITS)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[i]),
      .stat_o (stat[i])
    );
  end

  msd_merge #(.CHANNELS(CHANNELS)) u_merge (
    .op_i      (op),
    .channel_i (channel),
    .stat_i    (stat),
    .value_o   (value)
  );

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (acc) begin
      if (!out_vld_q || take) begin
        out_d     = value;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = value;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready_o = !skid_vld_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, out_q};

endmodule

[rtl/msd_lane.sv]
// ----------------------------------------------------------------------------
// msd_lane
// One debounce channel: sample history, debounced level, sticky edge flags.
// ----------------------------------------------------------------------------
module msd_lane #(
  parameter int unsigned HISTORY_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msd_pkg::lane_ctrl_t ctrl_i,
  output msd_pkg::lane_stat_t stat_o
);

  localparam logic [HISTORY_BITS-1:0] PatOff = {1'b1, {(HISTORY_BITS-1){1'b0}}};
  localparam logic [HISTORY_BITS-1:0] PatOn  = {1'b0, {(HISTORY_BITS-1){1'b1}}};

  logic [HISTORY_BITS-1:0] hist_q, hist_d;
  logic                    level_q, level_d;
  logic                    rise_q, rise_d;
  logic                    fall_q, fall_d;

  always_comb begin
    hist_d  = hist_q;
    level_d = level_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    if (ctrl_i.tick) begin
      hist_d = {hist_q[HISTORY_BITS-2:0], ctrl_i.pin};
      if (hist_d == PatOff) begin
        level_d = 1'b0;
        fall_d  = 1'b1;
      end else if (hist_d == PatOn) begin
        level_d = 1'b1;
        rise_d  = 1'b1;
      end
    end
    if (ctrl_i.clr_rise) rise_d = 1'b0;
    if (ctrl_i.clr_fall) fall_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      level_q <= 1'b0;
      rise_q  <= 1'b0;
      fall_q  <= 1'b0;
    end else begin
      hist_q  <= hist_d;
      level_q <= level_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
    end
  end

  assign stat_o = '{level: level_q, rise: rise_q, fall: fall_q};

endmodule

[rtl/msd_merge.sv]
// ----------------------------------------------------------------------------
// msd_merge
// Select the queried channel's level or flag from the lane bank.
// ----------------------------------------------------------------------------
module msd_merge #(
  parameter int unsigned CHANNELS = 32
) (
  input  logic [msd_pkg::OpW-1:0]   op_i,
  input  logic [msd_pkg::ChanW-1:0] channel_i,
  input  msd_pkg::lane_stat_t       stat_i [CHANNELS],
  output logic                      value_o
);

  msd_pkg::lane_stat_t sel;

  always_comb begin
    sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (channel_i == msd_pkg::ChanW'(i)) sel = sel | stat_i[i];
    end
  end

  always_comb begin
    unique case (op_i)
      msd_pkg::OP_LEVEL: value_o = sel.level;
      msd_pkg::OP_RISE:  value_o = sel.rise;
      msd_pkg::OP_FALL:  value_o = sel.fall;
      default:           value_o = 1'b0;
    endcase
  end

endmodule

[rtl/msd_checker.sv]
// ----------------------------------------------------------------------------
// msd_props
// Port-level checks on the debouncer's output buffering.
// ----------------------------------------------------------------------------
module msd_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);

  a_ready_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("ready low with no result waiting");

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o) |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:1] == 7'd0))
    else $error("result padding not zero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind multi_input_shift_debouncer msd_props u_msd_props (.*);

[bench/msd_checker.sv]
// ----------------------------------------------------------------------------
// msd_checker
// Watches both stream channels of the multi-input shift debouncer, keeps its
// own copy of the histories, levels and edge flags, predicts the value of
// every accepted beat and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module msd_checker #(
  parameter int unsigned CHANNELS     = 32,
  parameter int unsigned HISTORY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] pin_levels, [39:32] channel
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] operation
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,  // [0] value, [7:1] zero
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [HISTORY_BITS-1:0] PAT_FALL = {1'b1, {(HISTORY_BITS-1){1'b0}}};
  localparam logic [HISTORY_BITS-1:0] PAT_RISE = ~PAT_FALL;

  logic [HISTORY_BITS-1:0] history_q [CHANNELS];
  logic [CHANNELS-1:0]     level_q;
  logic [CHANNELS-1:0]     rise_q;
  logic [CHANNELS-1:0]     fall_q;
  logic                    expected_value_q [$];
  int                      errors;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic debounce_beat(input logic [msd_pkg::OpW-1:0] op,
                               input logic [msd_pkg::PinW-1:0] pins,
                               input logic [msd_pkg::ChanW-1:0] ch, output logic value);
    value = 1'b0;
    if (op == msd_pkg::OP_TICK) begin
      for (int i = 0; i < CHANNELS; i++) begin
        history_q[i] = {history_q[i][HISTORY_BITS-2:0], pins[i]};
        if (history_q[i] == PAT_FALL) begin
          level_q[i] = 1'b0;
          fall_q[i]  = 1'b1;
        end else if (history_q[i] == PAT_RISE) begin
          level_q[i] = 1'b1;
          rise_q[i]  = 1'b1;
        end
      end
    end else if (ch < CHANNELS) begin
      case (op)
        msd_pkg::OP_LEVEL: value = level_q[ch];
        msd_pkg::OP_RISE: begin
          value      = rise_q[ch];
          rise_q[ch] = 1'b0;
        end
        msd_pkg::OP_FALL: begin
          value      = fall_q[ch];
          fall_q[ch] = 1'b0;
        end
        msd_pkg::OP_CLEAR: begin
          rise_q[ch] = 1'b0;
          fall_q[ch] = 1'b0;
        end
        default: value = 1'b0;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic want;
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) history_q[i] = '0;
      level_q = '0;
      rise_q  = '0;
      fall_q  = '0;
      expected_value_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // take results first: a beat's result never leaves in its own cycle
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_value_q.size() == 0) begin
          report_mismatch("unexpected result beat", m_axis_tdata_i, 8'h00);
        end else begin
          want = expected_value_q.pop_front();
          if (m_axis_tdata_i[0] !== want)
            report_mismatch("value", {7'd0, m_axis_tdata_i[0]}, {7'd0, want});
          if (m_axis_tdata_i[7:1] !== 7'd0)
            report_mismatch("padding", {1'b0, m_axis_tdata_i[7:1]}, 8'h00);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        debounce_beat(s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[39:32], want);
        expected_value_q.push_back(want);
      end
      fail_count_o <= errors;
      pending_o    <= expected_value_q.size();
    end
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the multi-input shift debouncer: a short directed
// run over edge cases and every operation, then random ticks built from
// slowly changing pin levels with sparse glitches, mixed with queries over
// good and bad channel indices and unused operations, under random idling on
// both sides and one long receiver hold-off. Checking is done by msd_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHANNELS     = 32;
  localparam int unsigned HISTORY_BITS = 16;
  localparam int          RANDOM_BEATS = 1650;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          HOLD_AT      = 600;
  localparam logic [msd_pkg::OpW-1:0]   OP_MAX   = '1;
  localparam logic [msd_pkg::ChanW-1:0] CHAN_MAX = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [31:0] pin_levels, [39:32] channel
  logic [2:0]  s_axis_tuser = msd_pkg::OP_TICK;  // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] value, [7:1] zero
  int          fail_count;
  int          pending;
  logic        send_burst = 1'b0;
  logic        take_burst = 1'b0;
  logic [msd_pkg::PinW-1:0] steady_pins = '0;

  multi_input_shift_debouncer #(
    .CHANNELS    (CHANNELS),
    .HISTORY_BITS(HISTORY_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  msd_checker #(
    .CHANNELS    (CHANNELS),
    .HISTORY_BITS(HISTORY_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_beat(input logic [msd_pkg::OpW-1:0] op,
                           input logic [msd_pkg::PinW-1:0] pins,
                           input logic [msd_pkg::ChanW-1:0] ch);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ch, pins};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_beat();
    int unsigned pick;
    logic [msd_pkg::PinW-1:0] glitch;
    logic [msd_pkg::ChanW-1:0] ch;
    pick = $urandom_range(0, 99);
    ch = ($urandom_range(0, 6) == 0)
       ? msd_pkg::ChanW'($urandom_range(CHANNELS, CHAN_MAX))
       : msd_pkg::ChanW'($urandom_range(0, CHANNELS - 1));
    if (pick < 55) begin
      // drift the settled levels now and then, glitch around them
      if ($urandom_range(0, 23) == 0) steady_pins ^= $urandom() & $urandom();
      glitch = ($urandom_range(0, 2) == 0) ? '0
             : $urandom() & $urandom() & $urandom() & $urandom();
      if (pick < 6) send_beat(msd_pkg::OP_TICK, $urandom(), ch);
      else send_beat(msd_pkg::OP_TICK, steady_pins ^ glitch, ch);
    end else if (pick < 95) begin
      send_beat(msd_pkg::OpW'($urandom_range(msd_pkg::OP_LEVEL, msd_pkg::OP_CLEAR)),
                $urandom(), ch);
    end else begin
      send_beat(msd_pkg::OpW'($urandom_range(msd_pkg::OP_CLEAR + 1, OP_MAX)),
                $urandom(), ch);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(msd_pkg::OP_LEVEL, '0, '0);
    send_beat(msd_pkg::OP_RISE, '1, CHAN_MAX);
    send_beat(msd_pkg::OP_FALL, '0, msd_pkg::ChanW'(CHANNELS));
    send_beat(msd_pkg::OpW'(msd_pkg::OP_CLEAR + 1), '1, '0);
    send_beat(OP_MAX, '0, msd_pkg::ChanW'(CHANNELS - 1));
    send_beat(msd_pkg::OP_CLEAR, '0, '0);
    repeat (HISTORY_BITS - 1) send_beat(msd_pkg::OP_TICK, '1, '0);
    send_beat(msd_pkg::OP_LEVEL, '0, msd_pkg::ChanW'(CHANNELS - 1));
    send_beat(msd_pkg::OP_RISE, '0, '0);
    send_beat(msd_pkg::OP_RISE, '0, '0);
    send_beat(msd_pkg::OP_FALL, '0, '0);
    send_beat(msd_pkg::OP_CLEAR, '0, msd_pkg::ChanW'(CHANNELS - 1));
    send_beat(msd_pkg::OP_RISE, '0, msd_pkg::ChanW'(CHANNELS - 1));

    steady_pins = $urandom();
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_random_beat();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[multi_input_shift_debouncer] OK");
    end else begin
      $display("[multi_input_shift_debouncer] ERROR");
    end
    $finish;
  end

  initial begin
    int   wait_cycles;
    int   taken;
    logic held;
    taken = 0;
    held  = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 64 == 0) take_burst = ($urandom_range(0, 3) == 0);
      wait_cycles = take_burst ? 0 : $urandom_range(0, 14);
      if (!held && taken >= HOLD_AT) begin
        // hold off long enough for the block to fill and stall its input
        wait_cycles = HOLD_CYCLES;
        held = 1'b1;
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    #5_000_000;
    $display("[multi_input_shift_debouncer] ERROR");
    $finish;
  end

endmodule
